[design/smp_pkg.sv]
package smp_pkg;

  localparam int unsigned PosW    = 18;
  localparam int unsigned SpeedW  = 13;
  localparam int unsigned CmdW    = 14;
  localparam int unsigned StepW   = 8;
  localparam int unsigned BrakeW  = 16;
  localparam int unsigned MarginW = 12;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned ClassW  = 3;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  typedef logic signed [PosW-1:0] pos_t;

  localparam logic [IndexW-1:0] REG_KITTING = 3'd0;
  localparam logic [IndexW-1:0] REG_FRONT   = 3'd1;
  localparam logic [IndexW-1:0] REG_BACK    = 3'd2;
  localparam logic [IndexW-1:0] REG_STORE   = 3'd3;
  localparam logic [IndexW-1:0] REG_LIMIT   = 3'd4;
  localparam logic [IndexW-1:0] REG_STEP    = 3'd5;
  localparam logic [IndexW-1:0] REG_BRAKE   = 3'd6;
  localparam logic [IndexW-1:0] REG_MARGIN  = 3'd7;

  localparam logic [CodeW-1:0] STN_KITTING = 3'd0;
  localparam logic [CodeW-1:0] STN_FRONT   = 3'd1;
  localparam logic [CodeW-1:0] STN_BACK    = 3'd2;
  localparam logic [CodeW-1:0] STN_STORE   = 3'd3;

  localparam logic [ClassW-1:0] LOC_KITTING = 3'd0;
  localparam logic [ClassW-1:0] LOC_FRONT   = 3'd1;
  localparam logic [ClassW-1:0] LOC_BACK    = 3'd2;
  localparam logic [ClassW-1:0] LOC_STORE   = 3'd3;
  localparam logic [ClassW-1:0] LOC_UNKNOWN = 3'd4;

  localparam pos_t                RST_KITTING = 18'sd0;
  localparam pos_t                RST_FRONT   = 18'sd5600;
  localparam pos_t                RST_BACK    = 18'sd10600;
  localparam pos_t                RST_STORE   = 18'sd17000;
  localparam logic [SpeedW-1:0]   RST_LIMIT   = 13'd2000;
  localparam logic [StepW-1:0]    RST_STEP    = 8'd2;
  localparam logic [BrakeW-1:0]   RST_BRAKE   = 16'd900;
  localparam logic [MarginW-1:0]  RST_MARGIN  = 12'd50;

  typedef struct packed {
    pos_t                kitting;
    pos_t                front;
    pos_t                back;
    pos_t                store;
    logic [MarginW-1:0]  margin;
  } stn_cfg_t;

endpackage

[design/smp_classify.sv]
module smp_classify (
  input  smp_pkg::stn_cfg_t           cfg,
  input  smp_pkg::pos_t               position,
  output logic [smp_pkg::ClassW-1:0]  location_class
);

  logic near_kit;
  logic near_front;
  logic near_back;
  logic near_store;

  function automatic logic is_near(smp_pkg::pos_t p, smp_pkg::pos_t s,
                                   logic [smp_pkg::MarginW-1:0] m);
    logic signed [smp_pkg::PosW:0] d;
    logic [smp_pkg::PosW:0]        a;
    d = {p[smp_pkg::PosW-1], p} - {s[smp_pkg::PosW-1], s};
    a = d[smp_pkg::PosW] ? -d : d;
    return a <= {{(smp_pkg::PosW + 1 - smp_pkg::MarginW){1'b0}}, m};
  endfunction

  assign near_kit   = is_near(position, cfg.kitting, cfg.margin);
  assign near_front = is_near(position, cfg.front, cfg.margin);
  assign near_back  = is_near(position, cfg.back, cfg.margin);
  assign near_store = is_near(position, cfg.store, cfg.margin);

  always_comb begin
    if (near_kit) begin
      location_class = smp_pkg::LOC_KITTING;
    end else if (near_front) begin
      location_class = smp_pkg::LOC_FRONT;
    end else if (near_back) begin
      location_class = smp_pkg::LOC_BACK;
    end else if (near_store) begin
      location_class = smp_pkg::LOC_STORE;
    end else begin
      location_class = smp_pkg::LOC_UNKNOWN;
    end
  end

endmodule

[design/station_motion_profile.sv]
// Trapezoidal speed profile toward one of four stations.
// Input stream s_*: one request per item. s_tuser = 0 is a move request
// naming a station, s_tuser = 1 is a tick carrying the measured position.
// Output stream m_*: one result per request: accepted flag, signed speed
// command, moving flag and the station the position lies at, or unknown.
// Configuration port: cfg_wr writes cfg_data into register cfg_index
// (four station positions, speed limit, ramp step, brake distance, margin).
// A request's result is registered and shows on m_* after the edge that
// takes it. One request per cycle while the receiver does not stall; the
// profile state and single output register are updated in the accepting cycle.
// s_tready is high while the output register is empty or being drained, so a
// stalled receiver holds the result and blocks new requests only then.
// Reset (rst, synchronous): profile idle, speed zero, registers back to
// their default station layout and limits, output register empty.
module station_motion_profile (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [2:0] station_code, [20:3] position, [23:21] zero
  input  logic [smp_pkg::InDataW-1:0]     s_tdata,
  // [0] op
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] accepted, [14:1] speed_command, [15] moving, [18:16] location_class,
  // [23:19] zero
  output logic [smp_pkg::OutDataW-1:0]    m_tdata,
  input  logic                            cfg_wr,
  input  logic [smp_pkg::IndexW-1:0]      cfg_index,
  input  logic [smp_pkg::PosW-1:0]        cfg_data
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_UP   = 2'd1;
  localparam logic [1:0] PH_DOWN = 2'd2;

  smp_pkg::stn_cfg_t               stn;
  logic [smp_pkg::SpeedW-1:0]      speed_limit;
  logic [smp_pkg::StepW-1:0]       ramp_step;
  logic [smp_pkg::BrakeW-1:0]      brake_distance;

  logic [1:0]                      phase;
  logic [1:0]                      phase_next;
  logic                            reverse;
  logic                            reverse_next;
  smp_pkg::pos_t                   goal;
  smp_pkg::pos_t                   goal_next;
  logic [smp_pkg::SpeedW-1:0]      speed;
  logic [smp_pkg::SpeedW-1:0]      speed_next;

  logic                            op;
  logic [smp_pkg::CodeW-1:0]       station_code;
  smp_pkg::pos_t                   position;
  logic                            take;
  logic                            active;
  logic                            acc;
  smp_pkg::pos_t                   goal_sel;
  logic signed [smp_pkg::PosW+1:0] pos_w;
  logic signed [smp_pkg::PosW+1:0] lo_bound;
  logic signed [smp_pkg::PosW+1:0] hi_bound;
  logic                            cruise;
  logic                            before_goal;
  logic [smp_pkg::SpeedW:0]        speed_sum;
  logic [smp_pkg::SpeedW-1:0]      speed_dec;
  logic [smp_pkg::CmdW-1:0]        mag;
  logic [smp_pkg::CmdW-1:0]        cmd;
  logic [smp_pkg::ClassW-1:0]      loc;

  assign op           = s_tuser;
  assign station_code = s_tdata[smp_pkg::CodeW-1:0];
  assign position     = s_tdata[smp_pkg::CodeW +: smp_pkg::PosW];
  assign s_tready     = !m_tvalid || m_tready;
  assign take         = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stn.kitting    <= smp_pkg::RST_KITTING;
      stn.front      <= smp_pkg::RST_FRONT;
      stn.back       <= smp_pkg::RST_BACK;
      stn.store      <= smp_pkg::RST_STORE;
      stn.margin     <= smp_pkg::RST_MARGIN;
      speed_limit    <= smp_pkg::RST_LIMIT;
      ramp_step      <= smp_pkg::RST_STEP;
      brake_distance <= smp_pkg::RST_BRAKE;
    end else if (cfg_wr) begin
      case (cfg_index)
        smp_pkg::REG_KITTING: stn.kitting    <= cfg_data;
        smp_pkg::REG_FRONT:   stn.front      <= cfg_data;
        smp_pkg::REG_BACK:    stn.back       <= cfg_data;
        smp_pkg::REG_STORE:   stn.store      <= cfg_data;
        smp_pkg::REG_LIMIT:   speed_limit    <= cfg_data[smp_pkg::SpeedW-1:0];
        smp_pkg::REG_STEP:    ramp_step      <= cfg_data[smp_pkg::StepW-1:0];
        smp_pkg::REG_BRAKE:   brake_distance <= cfg_data[smp_pkg::BrakeW-1:0];
        smp_pkg::REG_MARGIN:  stn.margin     <= cfg_data[smp_pkg::MarginW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (station_code)
      smp_pkg::STN_KITTING: goal_sel = stn.kitting;
      smp_pkg::STN_FRONT:   goal_sel = stn.front;
      smp_pkg::STN_BACK:    goal_sel = stn.back;
      default:              goal_sel = stn.store;
    endcase
  end

  assign pos_w    = {{2{position[smp_pkg::PosW-1]}}, position};
  assign lo_bound = {{2{goal[smp_pkg::PosW-1]}}, goal} - {4'd0, brake_distance};
  assign hi_bound = {{2{goal[smp_pkg::PosW-1]}}, goal} + {4'd0, brake_distance};
  assign cruise   = reverse ? (pos_w > hi_bound) : (pos_w < lo_bound);
  assign before_goal = reverse ? (position > goal) : (position < goal);
  assign speed_sum   = {1'b0, speed} + {{(smp_pkg::SpeedW + 1 - smp_pkg::StepW){1'b0}}, ramp_step};
  assign speed_dec   = (speed > {{(smp_pkg::SpeedW - smp_pkg::StepW){1'b0}}, ramp_step})
                     ? speed - {{(smp_pkg::SpeedW - smp_pkg::StepW){1'b0}}, ramp_step}
                     : '0;

  always_comb begin
    phase_next   = phase;
    reverse_next = reverse;
    goal_next    = goal;
    speed_next   = speed;
    acc          = 1'b0;
    active       = (phase == PH_UP) || (phase == PH_DOWN);
    if (!active) begin
      phase_next = PH_IDLE;
    end
    if (!op) begin
      if (station_code <= smp_pkg::STN_STORE && !active) begin
        goal_next    = goal_sel;
        reverse_next = position > goal_sel;
        speed_next   = '0;
        phase_next   = PH_UP;
        acc          = 1'b1;
      end
    end else if (phase == PH_UP && cruise) begin
      if (speed >= speed_limit) begin
        speed_next = speed_limit;
      end else if (speed_sum > {1'b0, speed_limit}) begin
        speed_next = speed_limit;
      end else begin
        speed_next = speed_sum[smp_pkg::SpeedW-1:0];
      end
    end else if (phase == PH_UP || phase == PH_DOWN) begin
      if (!before_goal || speed == '0) begin
        speed_next = '0;
        phase_next = PH_IDLE;
      end else begin
        speed_next = speed_dec;
        phase_next = (speed_dec == '0) ? PH_IDLE : PH_DOWN;
      end
    end
  end

  assign mag = {1'b0, speed_next};
  assign cmd = (!op || active) ? (reverse_next ? -mag : mag) : '0;

  smp_classify u_classify (
    .cfg            (stn),
    .position       (position),
    .location_class (loc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      reverse  <= 1'b0;
      goal     <= '0;
      speed    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        phase   <= phase_next;
        reverse <= reverse_next;
        goal    <= goal_next;
        speed   <= speed_next;
      end
      if (take) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {5'd0, loc, (phase_next == PH_UP) || (phase_next == PH_DOWN), cmd, acc};
    end
  end

endmodule

[design/smp_checker.sv]
module smp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [smp_pkg::OutDataW-1:0]  m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("request produced no result");

  a_class: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[18:16] <= smp_pkg::LOC_UNKNOWN && m_tdata[23:19] == 5'd0)
    else $error("bad location class or padding");

  a_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[15] && m_tdata[14:1] == 14'd0)
    else $error("accepted move not started at rest");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] && m_tready |=> !(m_tvalid && m_tdata[0]))
    else $error("second move accepted while first active");

endmodule

bind station_motion_profile smp_checker u_smp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
